// ===== rtl/rau_pkg.sv =====
package rau_pkg;

	localparam int MW = 64;

	typedef enum logic [2:0] {
		ACT_NORM = 3'd0,
		ACT_ADD  = 3'd1,
		ACT_SUB  = 3'd2,
		ACT_MUL  = 3'd3,
		ACT_DIV  = 3'd4,
		ACT_CMP  = 3'd5,
		ACT_SPLIT = 3'd6,
		ACT_NONE = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_DEN = 2'd1,
		ST_DIV_ZERO = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_GCD = 2'd0,
		OP_DIV = 2'd1
	} op_t;

	typedef struct packed {
		logic    start;
		op_t     op;
		logic [MW-1:0] x;
		logic [MW-1:0] y;
	} rau_cmd_t;

	typedef struct packed {
		logic          done;
		logic [MW-1:0] quo;
		logic [MW-1:0] rem;
	} rau_rsp_t;

	typedef enum logic [4:0] {
		S_IDLE, S_LOADA, S_GA, S_QAN, S_QAD, S_LOADB, S_GB, S_QBN, S_QBD,
		S_MUL1, S_MUL2, S_COMB, S_RED, S_GR, S_QRN, S_QRD, S_SPQ, S_SPG, S_SPN,
		S_SPD, S_FIN, S_OUT
	} state_t;

endpackage

// ===== rtl/rau_divgcd.sv =====
// Shared iterative unit: restoring division (one quotient bit per cycle),
// or Euclid gcd built from repeated divisions.
module rau_divgcd (
	input  logic               clk,
	input  logic               arst_n,
	input  rau_pkg::rau_cmd_t  cmd,
	output rau_pkg::rau_rsp_t  rsp
);
	logic              busy_q, gcd_q, div_q;
	logic [6:0]        cnt_q;
	logic [63:0]       dvd_q, dvs_q, quo_q, rem_q, gx_q;
	logic [64:0]       trial;

	assign trial = {rem_q[63:0], dvd_q[63]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			div_q <= 1'b0;
			gcd_q <= 1'b0;
			cnt_q <= '0;
			gx_q <= '0;
			dvd_q <= '0;
			dvs_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			rsp.done <= 1'b0;
			rsp.quo <= '0;
			rsp.rem <= '0;
		end else begin
			rsp.done <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				gcd_q <= (cmd.op == rau_pkg::OP_GCD);
				div_q <= (cmd.op == rau_pkg::OP_DIV) || (cmd.y != '0);
				gx_q <= cmd.x;
				dvd_q <= cmd.x;
				dvs_q <= cmd.y;
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (div_q) begin
					if (!trial[64]) begin
						rem_q <= trial[63:0];
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= {rem_q[62:0], dvd_q[63]};
						quo_q <= {quo_q[62:0], 1'b0};
					end
					dvd_q <= {dvd_q[62:0], 1'b0};
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd63) begin
						div_q <= 1'b0;
						if (!gcd_q) begin
							busy_q <= 1'b0;
							rsp.done <= 1'b1;
							rsp.quo <= trial[64] ? {quo_q[62:0], 1'b0}
								: {quo_q[62:0], 1'b1};
							rsp.rem <= trial[64] ? {rem_q[62:0], dvd_q[63]}
								: trial[63:0];
						end
					end
				end else if (gcd_q) begin
					// rem_q holds x mod y; continue with (y, rem)
					if (rem_q == '0 || dvs_q == '0) begin
						busy_q <= 1'b0;
						rsp.done <= 1'b1;
						rsp.quo <= (dvs_q == '0) ? gx_q : dvs_q;
						rsp.rem <= '0;
					end else begin
						gx_q <= dvs_q;
						dvd_q <= dvs_q;
						dvs_q <= rem_q;
						rem_q <= '0;
						quo_q <= '0;
						cnt_q <= '0;
						div_q <= 1'b1;
					end
				end
			end
		end
	end
endmodule

// ===== rtl/rational_arithmetic_unit_top.sv =====
// Exact rational arithmetic on two fractions. Every item takes one
// operation code and two fractions, and yields one reduced result with a
// positive denominator and a status. All divisions and gcds are done by one
// shared restoring divider of 64 bits, which gives one quotient bit a cycle
// and also forms the gcd as a chain of divisions. An item with a zero
// denominator or the unused action goes straight to the final state without
// using the divider. The block accepts no new item until the result of the
// current one has been taken.
module rational_arithmetic_unit_top #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         action,
	input  logic signed [31:0] a_num,
	input  logic signed [31:0] a_den,
	input  logic signed [31:0] b_num,
	input  logic signed [31:0] b_den,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] res_num,
	output logic [30:0]        res_den,
	output logic [30:0]        whole_part,
	output logic               is_less,
	output logic               is_equal,
	output logic [1:0]         status
);
	localparam logic [63:0] LIM = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;

	rau_pkg::state_t state_q, state_d;
	rau_pkg::rau_cmd_t cmd;
	rau_pkg::rau_rsp_t rsp;

	logic [2:0]  act_q;
	logic [63:0] an_q, ad_q, bn_q, bd_q, rn_q, rd_q, g_q, x_q, y_q, wh_q;
	logic        aneg_q, bneg_q, rneg_q, zd_q, lt_q, eq_q;
	logic [1:0]  st_q;
	logic [63:0] mul_a, mul_b, mul_p;

	// Sign-extend from VALUE_WIDTH and take the magnitude.
	function automatic logic [64:0] mag(input logic [31:0] raw);
		logic [63:0] v;
		v = {{(64 - VALUE_WIDTH){raw[VALUE_WIDTH-1]}}, raw[VALUE_WIDTH-1:0]};
		return {v[63], v[63] ? (64'd0 - v) : v};
	endfunction

	logic [64:0] man, mad, mbn, mbd;
	assign man = mag(a_num);
	assign mad = mag(a_den);
	assign mbn = mag(b_num);
	assign mbd = mag(b_den);

	// A 32x32 multiplier, shared by the two product steps; S_COMB has its own.
	assign mul_p = mul_a[31:0] * mul_b[31:0];
	always_comb begin
		mul_a = an_q;
		mul_b = bd_q;
		unique case (state_q)
			rau_pkg::S_MUL1: begin
				mul_a = an_q;
				mul_b = (act_q == rau_pkg::ACT_MUL) ? bn_q : bd_q;
			end
			rau_pkg::S_MUL2: begin
				mul_a = (act_q == rau_pkg::ACT_MUL || act_q == rau_pkg::ACT_DIV) ? ad_q : bn_q;
				mul_b = (act_q == rau_pkg::ACT_MUL) ? bd_q
					: (act_q == rau_pkg::ACT_DIV) ? bn_q : ad_q;
			end
			default: ;
		endcase
	end

	logic bneg_eff;
	assign bneg_eff = (act_q == rau_pkg::ACT_SUB && bn_q != '0) ? !bneg_q : bneg_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rau_pkg::S_IDLE:  if (in_valid) state_d = rau_pkg::S_LOADA;
			rau_pkg::S_LOADA: state_d = zd_q ? rau_pkg::S_FIN : rau_pkg::S_GA;
			rau_pkg::S_GA:    if (rsp.done) state_d = rau_pkg::S_QAN;
			rau_pkg::S_QAN:   if (rsp.done) state_d = rau_pkg::S_QAD;
			rau_pkg::S_QAD:   if (rsp.done) state_d = rau_pkg::S_LOADB;
			rau_pkg::S_LOADB: state_d = (act_q == rau_pkg::ACT_NORM) ? rau_pkg::S_FIN
				: (act_q == rau_pkg::ACT_SPLIT) ? rau_pkg::S_SPQ : rau_pkg::S_GB;
			rau_pkg::S_GB:    if (rsp.done) state_d = rau_pkg::S_QBN;
			rau_pkg::S_QBN:   if (rsp.done) state_d = rau_pkg::S_QBD;
			rau_pkg::S_QBD:   if (rsp.done) state_d = rau_pkg::S_MUL1;
			rau_pkg::S_MUL1:  state_d = rau_pkg::S_MUL2;
			rau_pkg::S_MUL2:  state_d = rau_pkg::S_COMB;
			rau_pkg::S_COMB:  state_d = (act_q == rau_pkg::ACT_CMP
				|| (act_q == rau_pkg::ACT_DIV && bn_q == '0))
				? rau_pkg::S_FIN : rau_pkg::S_RED;
			// The combined fraction is in rn_q and rd_q only from here on.
			rau_pkg::S_RED:   state_d = rau_pkg::S_GR;
			rau_pkg::S_GR:    if (rsp.done) state_d = rau_pkg::S_QRN;
			rau_pkg::S_QRN:   if (rsp.done) state_d = rau_pkg::S_QRD;
			rau_pkg::S_QRD:   if (rsp.done) state_d = rau_pkg::S_FIN;
			rau_pkg::S_SPQ:   if (rsp.done) state_d = rau_pkg::S_SPG;
			rau_pkg::S_SPG:   if (rsp.done) state_d = rau_pkg::S_SPN;
			rau_pkg::S_SPN:   if (rsp.done) state_d = rau_pkg::S_SPD;
			rau_pkg::S_SPD:   if (rsp.done) state_d = rau_pkg::S_FIN;
			rau_pkg::S_FIN:   state_d = rau_pkg::S_OUT;
			rau_pkg::S_OUT:   if (out_ready) state_d = rau_pkg::S_IDLE;
			default:          state_d = rau_pkg::S_IDLE;
		endcase
	end

	// Command to the shared unit, issued one cycle on entering a wait state.
	logic entering;
	assign entering = (state_d != state_q);
	always_comb begin
		cmd.start = 1'b0;
		cmd.op = rau_pkg::OP_DIV;
		cmd.x = '0;
		cmd.y = '0;
		if (entering) begin
			unique case (state_d)
				rau_pkg::S_GA: begin cmd.start = 1'b1; cmd.op = rau_pkg::OP_GCD;
					cmd.x = an_q; cmd.y = ad_q; end
				rau_pkg::S_GB: begin cmd.start = 1'b1; cmd.op = rau_pkg::OP_GCD;
					cmd.x = bn_q; cmd.y = bd_q; end
				rau_pkg::S_GR: begin cmd.start = 1'b1; cmd.op = rau_pkg::OP_GCD;
					cmd.x = rn_q; cmd.y = rd_q; end
				rau_pkg::S_SPG: begin cmd.start = 1'b1; cmd.op = rau_pkg::OP_GCD;
					cmd.x = rsp.rem; cmd.y = ad_q; end
				rau_pkg::S_QAN, rau_pkg::S_QBN, rau_pkg::S_QRN, rau_pkg::S_SPN: begin
					cmd.start = 1'b1;
					cmd.x = (state_q == rau_pkg::S_GA) ? an_q
						: (state_q == rau_pkg::S_GB) ? bn_q
						: (state_q == rau_pkg::S_GR) ? rn_q : rn_q;
					cmd.y = (rsp.quo == '0) ? 64'd1 : rsp.quo;
				end
				rau_pkg::S_QAD, rau_pkg::S_QBD, rau_pkg::S_QRD, rau_pkg::S_SPD: begin
					cmd.start = 1'b1;
					cmd.x = (state_q == rau_pkg::S_QAN) ? ad_q
						: (state_q == rau_pkg::S_QBN) ? bd_q : rd_q;
					cmd.y = (g_q == '0) ? 64'd1 : g_q;
				end
				rau_pkg::S_SPQ: begin cmd.start = 1'b1; cmd.x = an_q; cmd.y = ad_q; end
				default: ;
			endcase
		end
	end

	rau_divgcd u_div (.clk(clk), .arst_n(arst_n), .cmd(cmd), .rsp(rsp));

	logic fit_r;
	assign fit_r = (rd_q <= LIM) && (rneg_q ? (rn_q <= LIM + 64'd1) : (rn_q <= LIM));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rau_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			rau_pkg::S_IDLE: if (in_valid) begin
				act_q <= action;
				aneg_q <= man[64] ^ mad[64];
				an_q <= man[63:0];
				ad_q <= mad[63:0];
				bneg_q <= mbn[64] ^ mbd[64];
				bn_q <= mbn[63:0];
				bd_q <= mbd[63:0];
				wh_q <= '0;
				lt_q <= 1'b0;
				eq_q <= 1'b0;
				rneg_q <= 1'b0;
				rn_q <= '0;
				rd_q <= 64'd1;
				st_q <= rau_pkg::ST_OK;
				zd_q <= (action == rau_pkg::ACT_NONE) || (mad[63:0] == '0) ||
					(action != rau_pkg::ACT_NORM && action != rau_pkg::ACT_SPLIT
					&& mbd[63:0] == '0);
			end
			rau_pkg::S_LOADA: if (zd_q && act_q != rau_pkg::ACT_NONE)
				st_q <= rau_pkg::ST_ZERO_DEN;
			rau_pkg::S_GA, rau_pkg::S_GB, rau_pkg::S_GR, rau_pkg::S_SPG:
				if (rsp.done) g_q <= rsp.quo;
			rau_pkg::S_QAN: if (rsp.done) an_q <= rsp.quo;
			rau_pkg::S_QAD: if (rsp.done) begin
				ad_q <= (an_q == '0) ? 64'd1 : rsp.quo;
				if (an_q == '0) aneg_q <= 1'b0;
			end
			rau_pkg::S_LOADB: if (act_q == rau_pkg::ACT_NORM) begin
				rn_q <= an_q; rd_q <= ad_q; rneg_q <= aneg_q;
			end
			rau_pkg::S_QBN: if (rsp.done) bn_q <= rsp.quo;
			rau_pkg::S_QBD: if (rsp.done) begin
				bd_q <= (bn_q == '0) ? 64'd1 : rsp.quo;
				if (bn_q == '0) bneg_q <= 1'b0;
			end
			rau_pkg::S_MUL1: x_q <= mul_p;
			rau_pkg::S_MUL2: y_q <= mul_p;
			rau_pkg::S_COMB: begin
				unique case (act_q)
					rau_pkg::ACT_ADD, rau_pkg::ACT_SUB: begin
						rd_q <= ad_q[31:0] * bd_q[31:0];
						if (aneg_q == bneg_eff) begin
							rn_q <= x_q + y_q; rneg_q <= aneg_q;
						end else if (x_q >= y_q) begin
							rn_q <= x_q - y_q; rneg_q <= aneg_q;
						end else begin
							rn_q <= y_q - x_q; rneg_q <= bneg_eff;
						end
					end
					rau_pkg::ACT_MUL, rau_pkg::ACT_DIV: begin
						rn_q <= x_q; rd_q <= y_q; rneg_q <= aneg_q ^ bneg_q;
						if (act_q == rau_pkg::ACT_DIV && bn_q == '0)
							st_q <= rau_pkg::ST_DIV_ZERO;
					end
					default: begin
						lt_q <= (aneg_q != bneg_q) ? aneg_q
							: aneg_q ? (x_q > y_q) : (x_q < y_q);
						eq_q <= (aneg_q == bneg_q) && (an_q == bn_q) && (ad_q == bd_q);
					end
				endcase
			end
			rau_pkg::S_SPQ: if (rsp.done) begin
				wh_q <= rsp.quo; rn_q <= rsp.rem; rd_q <= ad_q; rneg_q <= aneg_q;
			end
			rau_pkg::S_QRN, rau_pkg::S_SPN: if (rsp.done) rn_q <= rsp.quo;
			rau_pkg::S_QRD, rau_pkg::S_SPD: if (rsp.done) begin
				rd_q <= (rn_q == '0) ? 64'd1 : rsp.quo;
				if (rn_q == '0) rneg_q <= 1'b0;
			end
			rau_pkg::S_FIN: if (st_q == rau_pkg::ST_OK) begin
				if (act_q != rau_pkg::ACT_CMP && act_q != rau_pkg::ACT_NONE && (!fit_r
					|| (act_q == rau_pkg::ACT_SPLIT && (wh_q > LIM || ad_q > LIM
					|| (aneg_q ? an_q > LIM + 64'd1 : an_q > LIM)))))
					st_q <= rau_pkg::ST_OVERFLOW;
			end
			default: ;
		endcase
	end

	logic ok;
	logic [63:0] sn;
	assign ok = (st_q == rau_pkg::ST_OK);
	assign sn = rneg_q ? (64'd0 - rn_q) : rn_q;
	assign in_ready = (state_q == rau_pkg::S_IDLE);
	assign out_valid = (state_q == rau_pkg::S_OUT);
	assign res_num = ok ? sn[31:0] : 32'd0;
	assign res_den = ok ? rd_q[30:0] : 31'd1;
	assign whole_part = ok ? wh_q[30:0] : 31'd0;
	assign is_less = ok & lt_q;
	assign is_equal = ok & eq_q;
	assign status = st_q;
endmodule

// ===== rtl/rau_checker.sv =====
module rau_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [30:0] res_den,
	input logic        is_less,
	input logic [1:0]  status
);
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("ready while result pending");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("second item taken");
	a_den: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> res_den != 31'd0) else $error("zero denominator out");
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != rau_pkg::ST_OK |-> !is_less && res_den == 31'd1)
		else $error("error result not cleared");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(res_den) && $stable(status))
		else $error("result dropped or changed while waiting");
endmodule

bind rational_arithmetic_unit_top rau_checker u_chk (.*);
